@@ rtl/core/sbpd_pkg.sv @@
// sbpd_pkg: shared types, constants and the log gain table of the band peak meter
`default_nettype none

package sbpd_pkg;

  localparam int unsigned MAX_BANDS         = 64;
  localparam int unsigned MAX_BINS_PER_BAND = 256;

  localparam int unsigned BAND_W  = $clog2(MAX_BANDS);          // band number bits
  localparam int unsigned BIN_W   = $clog2(MAX_BINS_PER_BAND);  // bin counter bits
  localparam int unsigned MAG_W   = 16;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned PROD_W  = SUM_W + GAIN_W;
  localparam int unsigned GAIN_FB = 13;                         // gain fraction bits
  localparam int unsigned LVL_W   = 16;
  localparam int unsigned DECAY_W = 16;
  localparam int unsigned BPB_W   = 9;
  localparam int unsigned BCNT_W  = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LVL_W-1:0] LEVEL_ONE = 16'd32768;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_PER_BAND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT    = 2'd2;

  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd1638;
  localparam logic [BPB_W-1:0]   BPB_RESET   = 9'd8;
  localparam logic [BCNT_W-1:0]  BCNT_RESET  = 7'd64;

  // ln(k+2) in Q3.13, rounded to nearest
  localparam logic [GAIN_W-1:0] LN_Q13 [MAX_BANDS] = '{
    16'd5678,  16'd9000,  16'd11357, 16'd13185, 16'd14678, 16'd15941, 16'd17035, 16'd18000,
    16'd18863, 16'd19644, 16'd20356, 16'd21012, 16'd21619, 16'd22184, 16'd22713, 16'd23210,
    16'd23678, 16'd24121, 16'd24541, 16'd24941, 16'd25322, 16'd25686, 16'd26035, 16'd26369,
    16'd26690, 16'd26999, 16'd27297, 16'd27585, 16'd27863, 16'd28131, 16'd28391, 16'd28643,
    16'd28888, 16'd29125, 16'd29356, 16'd29581, 16'd29799, 16'd30012, 16'd30219, 16'd30422,
    16'd30619, 16'd30812, 16'd31000, 16'd31184, 16'd31364, 16'd31540, 16'd31713, 16'd31882,
    16'd32047, 16'd32210, 16'd32369, 16'd32525, 16'd32678, 16'd32828, 16'd32976, 16'd33121,
    16'd33263, 16'd33403, 16'd33541, 16'd33676, 16'd33809, 16'd33941, 16'd34070, 16'd34197
  };

  // a finished band leaving the accumulator
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [BAND_W-1:0] band;
    logic              last;
  } band_t;

  // a scaled and clamped band level
  typedef struct packed {
    logic [LVL_W-1:0]  level;
    logic [BAND_W-1:0] band;
    logic              last;
  } level_t;

endpackage

`default_nettype wire

@@ rtl/core/sbpd_accum.sv @@
// sbpd_accum: bin and band counters and the running band sum
`default_nettype none

module sbpd_accum (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [sbpd_pkg::BPB_W-1:0]  bins_per_band,
  input  wire logic [sbpd_pkg::BCNT_W-1:0] band_count,
  input  wire logic                        in_fire,
  input  wire logic [sbpd_pkg::MAG_W-1:0]  magnitude,
  input  wire logic                        frame_start,
  output logic                             band_done,
  output sbpd_pkg::band_t                  band_item
);
  import sbpd_pkg::*;

  logic [BIN_W-1:0]  bin_r,  bin_nxt;
  logic [BAND_W-1:0] band_r, band_nxt;
  logic [SUM_W-1:0]  sum_r,  sum_nxt;

  logic [BIN_W-1:0]  bin_base;
  logic [BAND_W-1:0] band_cur;
  logic [SUM_W-1:0]  sum_base;
  logic [BIN_W:0]    count;
  logic [BPB_W-1:0]  eff_bins;
  logic [BCNT_W-1:0] eff_bands;
  logic [BCNT_W-1:0] band_inc;
  logic              last;

  always_comb begin
    // frame start restarts both counters and drops a partial band
    bin_base = frame_start ? '0 : bin_r;
    band_cur = frame_start ? '0 : band_r;
    sum_base = frame_start ? '0 : sum_r;

    if (bins_per_band == '0) begin
      eff_bins = BPB_W'(1);
    end else if (bins_per_band > BPB_W'(MAX_BINS_PER_BAND)) begin
      eff_bins = BPB_W'(MAX_BINS_PER_BAND);
    end else begin
      eff_bins = bins_per_band;
    end

    if (band_count == '0) begin
      eff_bands = BCNT_W'(1);
    end else if (band_count > BCNT_W'(MAX_BANDS)) begin
      eff_bands = BCNT_W'(MAX_BANDS);
    end else begin
      eff_bands = band_count;
    end

    count     = {1'b0, bin_base} + (BIN_W+1)'(1);
    sum_nxt   = sum_base + SUM_W'(magnitude);
    band_done = count >= eff_bins;
    band_inc  = BCNT_W'(band_cur) + BCNT_W'(1);
    last      = band_inc >= eff_bands;

    band_item.sum  = sum_nxt;
    band_item.band = band_cur;
    band_item.last = last;

    if (band_done) begin
      bin_nxt  = '0;
      band_nxt = last ? '0 : band_inc[BAND_W-1:0];
    end else begin
      bin_nxt  = count[BIN_W-1:0];
      band_nxt = band_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r  <= '0;
      band_r <= '0;
      sum_r  <= '0;
    end else if (in_fire) begin
      bin_r  <= bin_nxt;
      band_r <= band_nxt;
      sum_r  <= band_done ? '0 : sum_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sbpd_scale.sv @@
// sbpd_scale: band register, log gain multiply and clamp to full scale
`default_nettype none

module sbpd_scale (
  input  wire logic        clk,
  input  wire logic        load,
  input  sbpd_pkg::band_t  band_in,
  output sbpd_pkg::level_t level_out
);
  import sbpd_pkg::*;

  band_t                      band_r;
  logic [PROD_W-1:0]          prod;
  logic [PROD_W-GAIN_FB-1:0]  scaled;

  always_ff @(posedge clk) begin
    if (load) begin
      band_r <= band_in;
    end
  end

  always_comb begin
    prod   = PROD_W'(band_r.sum) * PROD_W'(LN_Q13[band_r.band]);
    scaled = prod[PROD_W-1:GAIN_FB];
    level_out.level = (scaled > (PROD_W-GAIN_FB)'(LEVEL_ONE)) ? LEVEL_ONE
                                                                : scaled[LVL_W-1:0];
    level_out.band  = band_r.band;
    level_out.last  = band_r.last;
  end

endmodule

`default_nettype wire

@@ rtl/core/sbpd_hold.sv @@
// sbpd_hold: held level store with peak hold and decay update
`default_nettype none

module sbpd_hold (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [sbpd_pkg::DECAY_W-1:0] decay_step,
  input  wire logic                         load,
  input  sbpd_pkg::level_t                  level_in,
  input  wire logic                         commit,
  output sbpd_pkg::level_t                  result
);
  import sbpd_pkg::*;

  logic [LVL_W-1:0]     held_mem [MAX_BANDS];
  logic [MAX_BANDS-1:0] valid_r;

  level_t           cur_r;
  logic [LVL_W-1:0] rd_r;
  logic             rd_vld_r;
  logic             byp_hit_r;
  logic [LVL_W-1:0] byp_r;

  logic [LVL_W-1:0]   held;
  logic signed [17:0] floor_lvl;
  logic signed [17:0] new_lvl;
  logic [LVL_W-1:0]   new_held;

  always_comb begin
    held      = byp_hit_r ? byp_r : (rd_vld_r ? rd_r : '0);
    floor_lvl = $signed({2'b00, held}) - $signed({2'b00, decay_step});
    new_lvl   = $signed({2'b00, cur_r.level});
    if (new_lvl >= floor_lvl) begin
      new_held = cur_r.level;
    end else if (floor_lvl < 18'sd0) begin
      new_held = '0;
    end else begin
      new_held = floor_lvl[LVL_W-1:0];
    end
    result.level = new_held;
    result.band  = cur_r.band;
    result.last  = cur_r.last;
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (commit) begin
      held_mem[cur_r.band] <= new_held;
    end
    if (load) begin
      rd_r <= held_mem[level_in.band];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r     <= level_in;
      rd_vld_r  <= valid_r[level_in.band];
      // same band written at this edge: take the fresh value
      byp_hit_r <= commit && (cur_r.band == level_in.band);
      byp_r     <= new_held;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (commit) begin
      valid_r[cur_r.band] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/spectrum_band_peak_decay.sv @@
// spectrum_band_peak_decay: band levels from fft bins with peak hold and decay
//
//  channel  dir  fields (low bit first)                        marks
//  in_*     in   tdata: bin_magnitude[15:0]                    tuser: frame_start
//  out_*    out  tdata: band_index[5:0] band_level[21:6] pad   tlast: last_band
//  cfg_*    in   index 0 decay_step, 1 bins_per_band, 2 band_count
//
//  one bin transfer per cycle is taken unless the band register is full and cannot move on;
//  after its final bin a band result is registered after each stage (accumulate, multiply, hold compare)
//  the held level store is 64 entries with valid flags, so no clearing pass
//  after reset: everything is usable on the first cycle with rst_n high
//  a stalled output holds the pipe stage by stage; bins keep flowing while the
//  accumulator is building a band and the band register has room
`default_nettype none

module spectrum_band_peak_decay (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // bin stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [15:0]                     in_tdata,   // bin_magnitude
  input  wire logic                            in_tuser,   // frame_start
  // band results
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [23:0]                          out_tdata,  // band_index, band_level, zeros
  output logic                                 out_tlast,  // last_band
  // configuration writes
  input  wire logic                            cfg_we,
  input  wire logic [sbpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sbpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sbpd_pkg::*;

  // configuration registers
  logic [DECAY_W-1:0] decay_r;
  logic [BPB_W-1:0]   bpb_r;
  logic [BCNT_W-1:0]  bcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= DECAY_RESET;
      bpb_r   <= BPB_RESET;
      bcnt_r  <= BCNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DECAY_STEP:    decay_r <= cfg_wdata;
        CFG_BINS_PER_BAND: bpb_r   <= cfg_wdata[BPB_W-1:0];
        CFG_BAND_COUNT:    bcnt_r  <= cfg_wdata[BCNT_W-1:0];
        default:           ;  // unused index, write dropped
      endcase
    end
  end

  // stage occupancy and moves
  logic s1_valid_r, s1_valid_nxt;   // band register in front of the multiplier
  logic s2_valid_r, s2_valid_nxt;   // scaled level in front of the hold compare
  logic out_valid_r, out_valid_nxt;
  logic move_s2, move_s1, in_fire;

  logic   band_done;
  band_t  band_item;
  level_t level_s1;
  level_t result;

  always_comb begin
    move_s2   = s2_valid_r && (!out_valid_r || out_tready);
    move_s1   = s1_valid_r && (!s2_valid_r || move_s2);
    in_tready = !s1_valid_r || move_s1;
    in_fire   = in_tvalid && in_tready;

    s1_valid_nxt  = (in_fire && band_done) || (s1_valid_r && !move_s1);
    s2_valid_nxt  = move_s1 || (s2_valid_r && !move_s2);
    out_valid_nxt = move_s2 || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  sbpd_accum u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .bins_per_band (bpb_r),
    .band_count    (bcnt_r),
    .in_fire       (in_fire),
    .magnitude     (in_tdata),
    .frame_start   (in_tuser),
    .band_done     (band_done),
    .band_item     (band_item)
  );

  // band register loads whenever a finishing bin is taken
  sbpd_scale u_scale (
    .clk       (clk),
    .load      (in_fire && band_done),
    .band_in   (band_item),
    .level_out (level_s1)
  );

  sbpd_hold u_hold (
    .clk        (clk),
    .rst_n      (rst_n),
    .decay_step (decay_r),
    .load       (move_s1),
    .level_in   (level_s1),
    .commit     (move_s2),
    .result     (result)
  );

  // output register
  logic [BAND_W-1:0] out_band_r;
  logic [LVL_W-1:0]  out_level_r;
  logic              out_last_r;

  always_ff @(posedge clk) begin
    if (move_s2) begin
      out_band_r  <= result.band;
      out_level_r <= result.level;
      out_last_r  <= result.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_level_r, out_band_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

@@ rtl/core/sbpd_checker.sv @@
// sbpd_checker: port level checks on the band peak meter, bound to the top level
`default_nettype none

module sbpd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // clamp and decay never exceed full scale
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[21:6] <= 16'd32768)
    else $error("band level above full scale");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:22] == 2'b00)
    else $error("padding bits set");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown straight after reset");

  // input free and no result just after reset is released
  a_reset_release: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> (in_tready && !out_tvalid) ##1 !out_tvalid)
    else $error("pipe not empty after reset release");

endmodule

bind spectrum_band_peak_decay sbpd_checker u_sbpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
